FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the partition block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition implies consequence in the same cycle.
`define BTP_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Condition implies consequence in the next cycle.
`define BTP_ASSERT_NXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTP_ASSERT_IMP(label, cond, cons)
`define BTP_ASSERT_NXT(label, cond, cons)
`endif
`endif

FILE: sv/btp_pkg.sv
// Shared types and constants of the balanced two-team partition block.
package btp_pkg;

    localparam int VALUE_W           = 16;
    localparam int DIFF_W            = 20;
    localparam int MAX_ITEMS_DEFAULT = 16;
    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0] item_value;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic [DIFF_W-1:0] min_difference;
        logic              overflow;
    } out_item_t;

endpackage

FILE: sv/btp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/btp_comb_step.sv
// Next team mask with the same number of members, and a flag past the candidate span.
module btp_comb_step #(
    parameter int MAX_ITEMS = btp_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic [MAX_ITEMS-1:0]             mask,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]   span,
    output logic [MAX_ITEMS-1:0]             next_mask,
    output logic                             wrapped
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SH_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [MAX_ITEMS-1:0] low_bit;
    logic [MAX_ITEMS-1:0] ripple;
    logic [MAX_ITEMS-1:0] ones;
    logic [MAX_ITEMS-1:0] in_span;
    logic [SH_W-1:0]      shift;

    assign low_bit = mask & (~mask + MAX_ITEMS'(1));
    assign ripple  = mask + low_bit;

    // Position of the lowest set bit; low_bit is one-hot, so OR the indexes.
    always_comb
    begin
        shift = '0;
        for (int b = 0; b < MAX_ITEMS; b++)
        begin
            if (low_bit[b])
            begin
                shift = shift | SH_W'(b);
            end
        end
    end

    assign ones      = ((ripple ^ mask) >> 2) >> shift;
    assign next_mask = ripple | ones;

    always_comb
    begin
        for (int b = 0; b < MAX_ITEMS; b++)
        begin
            in_span[b] = CNT_W'(b) < span;
        end
    end

    assign wrapped = |(next_mask & ~in_span);

endmodule

FILE: sv/balanced_two_team_partition.sv
// Top level of the balanced two-team partition search.
// Items load one per cycle into a RAM while their total is kept. After the
// item marked last, the block walks every team of floor(n/2) items that holds
// item 0, reading the stored values back through the single RAM read port one
// per cycle: each team is read and summed in S_EVAL and compared in S_CMP,
// and a one-item set skips the search. Items beyond MAX_ITEMS are dropped and
// flagged with overflow; no item is taken during a search. A finished result
// waits in an output register while the next set loads.
`include "assert_macros.svh"

module balanced_two_team_partition #(
    parameter int MAX_ITEMS = btp_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  btp_pkg::in_item_t item,
    output logic              result_valid,
    input  logic              result_ready,
    output btp_pkg::out_item_t result
);

    import btp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int TOTAL_W = VALUE_W + $clog2(MAX_ITEMS);
    localparam logic [TOTAL_W:0] DIFF_CAP = (TOTAL_W + 1)'(DIFF_MAX);

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_EVAL,
        S_CMP,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic                 ovf_reg;
    logic [TOTAL_W-1:0]   best_reg;
    logic [MAX_ITEMS-1:0] mask_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 pend_reg;
    logic                 take_reg;
    logic                 end_reg;
    logic [TOTAL_W-1:0]   acc_reg;
    logic [TOTAL_W-1:0]   sum_reg;
    logic                 first_reg;
    logic                 result_valid_reg;
    out_item_t            result_reg;

    logic                 wr_en;
    logic                 rd_en;
    logic [VALUE_W-1:0]   rd_data;
    logic [ADDR_W-1:0]    sel_idx;
    logic                 take;
    logic [TOTAL_W-1:0]   term;
    logic [CNT_W-1:0]     pick;
    logic [CNT_W-1:0]     span;
    logic [MAX_ITEMS-1:0] init_mask;
    logic [MAX_ITEMS-1:0] next_mask;
    logic                 wrapped;
    logic [TOTAL_W:0]     dbl;
    logic [TOTAL_W:0]     tot_ext;
    logic [TOTAL_W:0]     diff_wide;
    logic [TOTAL_W-1:0]   diff;
    logic [TOTAL_W:0]     best_ext;
    logic [DIFF_W-1:0]    best_sat;

    assign item_ready   = (state_reg == S_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign wr_en = item_valid && item_ready && (count_reg < CNT_W'(MAX_ITEMS));
    assign rd_en = (state_reg == S_EVAL) && (issue_reg < count_reg);

    btp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (item.item_value),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Item 0 is always on the team; item i is on it when mask bit i-1 is set.
    assign sel_idx = issue_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign take    = (issue_reg == '0) || mask_reg[sel_idx];
    assign term    = (pend_reg && take_reg) ? TOTAL_W'(rd_data) : '0;

    assign pick = (count_reg >> 1) - CNT_W'(1);
    assign span = count_reg - CNT_W'(1);

    always_comb
    begin
        for (int b = 0; b < MAX_ITEMS; b++)
        begin
            init_mask[b] = CNT_W'(b) < pick;
        end
    end

    btp_comb_step #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_step (
        .mask      (mask_reg),
        .span      (span),
        .next_mask (next_mask),
        .wrapped   (wrapped)
    );

    // |team - rest| = |2*team - total|
    assign dbl       = {sum_reg, 1'b0};
    assign tot_ext   = {1'b0, total_reg};
    assign diff_wide = (dbl >= tot_ext) ? (dbl - tot_ext) : (tot_ext - dbl);
    assign diff      = diff_wide[TOTAL_W-1:0];

    assign best_ext = {1'b0, best_reg};
    assign best_sat = (best_ext > DIFF_CAP) ? DIFF_MAX : DIFF_W'(best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            total_reg        <= '0;
            ovf_reg          <= 1'b0;
            best_reg         <= '0;
            mask_reg         <= '0;
            issue_reg        <= '0;
            pend_reg         <= 1'b0;
            take_reg         <= 1'b0;
            end_reg          <= 1'b0;
            acc_reg          <= '0;
            sum_reg          <= '0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // Drop the valid on acceptance unless a new result replaces it.
            if (result_valid_reg && result_ready && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (item_valid)
                    begin
                        if (count_reg < CNT_W'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            total_reg <= total_reg + TOTAL_W'(item.item_value);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (item.last_item)
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end

                S_INIT:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        best_reg  <= total_reg;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        mask_reg  <= init_mask;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        acc_reg   <= '0;
                        first_reg <= 1'b1;
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    pend_reg <= rd_en;
                    take_reg <= take;
                    end_reg  <= (issue_reg == span);
                    if (pend_reg)
                    begin
                        if (end_reg)
                        begin
                            sum_reg   <= acc_reg + term;
                            state_reg <= S_CMP;
                        end
                        else
                        begin
                            acc_reg <= acc_reg + term;
                        end
                    end
                end

                S_CMP:
                begin
                    if (first_reg || (diff < best_reg))
                    begin
                        best_reg <= diff;
                    end
                    first_reg <= 1'b0;
                    if ((pick == '0) || wrapped)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        mask_reg  <= next_mask;
                        issue_reg <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_EVAL;
                    end
                end

                S_FINISH:
                begin
                    // Hold the result until the output register is free.
                    if (!result_valid_reg || result_ready)
                    begin
                        result_reg.min_difference <= best_sat;
                        result_reg.overflow       <= ovf_reg;
                        result_valid_reg          <= 1'b1;
                        count_reg                 <= '0;
                        total_reg                 <= '0;
                        ovf_reg                   <= 1'b0;
                        state_reg                 <= S_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `BTP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `BTP_ASSERT_IMP(a_write_in_load, wr_en, state_reg == S_LOAD)
    `BTP_ASSERT_IMP(a_best_le_total, (state_reg == S_CMP) && !first_reg, best_reg <= total_reg)
    `BTP_ASSERT_NXT(a_last_starts_search, item_valid && item_ready && item.last_item, !item_ready)

endmodule

FILE: tb/split_gap_checker.sv
// Checker for the partition block: predicts each set's least split gap and compares results.
`timescale 1ns / 1ps

module split_gap_checker #(
    parameter int MAX_ITEMS = btp_pkg::MAX_ITEMS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  btp_pkg::in_item_t  item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  btp_pkg::out_item_t result,
    output int                 error_count,
    output int                 results_checked,
    output int                 gaps_pending
);
    import btp_pkg::*;

    int unsigned set_values[$];
    logic        set_overflow = 1'b0;
    out_item_t   gaps_due[$];
    int          fails = 0;
    int          checked = 0;

    // Best team of floor(n/2) holding item 0; the search order does not matter for the minimum.
    function automatic logic [DIFF_W-1:0] least_split_gap(input int unsigned vals[$]);
        longint unsigned total;
        longint unsigned team;
        longint unsigned gap;
        longint unsigned best;
        int              n;
        total = 0;
        n = vals.size();
        foreach (vals[i])
            total += 64'(vals[i]);
        best = total;
        if (n >= 2)
        begin
            best = '1;
            for (longint unsigned pick = 0; pick < (64'd1 << (n - 1)); pick++)
            begin
                if ($countones(pick) == n / 2 - 1)
                begin
                    team = 64'(vals[0]);
                    for (int i = 1; i < n; i++)
                        if (pick[i-1])
                            team += 64'(vals[i]);
                    gap = (2 * team > total) ? 2 * team - total : total - 2 * team;
                    if (gap < best)
                        best = gap;
                end
            end
        end
        return (best > DIFF_MAX) ? DIFF_MAX : best[DIFF_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t fresh;
        if (!rst_n)
        begin
            set_values.delete();
            gaps_due.delete();
            set_overflow = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (gaps_due.size() == 0)
                begin
                    fails++;
                    $error("unexpected result: min_difference %0d overflow %0b",
                           result.min_difference, result.overflow);
                end
                else
                begin
                    want = gaps_due.pop_front();
                    checked++;
                    if (result.min_difference !== want.min_difference)
                    begin
                        fails++;
                        $error("min_difference: expected %0d, actual %0d",
                               want.min_difference, result.min_difference);
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        fails++;
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, result.overflow);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                // Drop items past the store depth, but remember that it happened.
                if (set_values.size() < MAX_ITEMS)
                    set_values.push_back(32'(item.item_value));
                else
                    set_overflow = 1'b1;
                if (item.last_item)
                begin
                    fresh.min_difference = least_split_gap(set_values);
                    fresh.overflow = set_overflow;
                    gaps_due.push_back(fresh);
                    set_values.delete();
                    set_overflow = 1'b0;
                end
            end
        end
        error_count <= fails;
        results_checked <= checked;
        gaps_pending <= gaps_due.size();
    end

endmodule

FILE: tb/balanced_two_team_partition_test.sv
// Top of the partition testbench: clock, reset, item and result stimulus, and the verdict.
`timescale 1ns / 1ps

module balanced_two_team_partition_test;
    import btp_pkg::*;

    localparam int MAX_ITEMS      = MAX_ITEMS_DEFAULT;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int CYCLE_LIMIT    = 3_000_000;

    typedef enum {FULL_RANGE, NARROW, EXTREMES} value_style_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    in_item_t   item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    out_item_t  result;

    logic       calm = 1'b0;
    int         items_sent = 0;
    int         sets_sent = 0;
    int         cycle_count = 0;
    int         error_count;
    int         results_checked;
    int         gaps_pending;

    balanced_two_team_partition #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    split_gap_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .error_count(error_count),
        .results_checked(results_checked),
        .gaps_pending(gaps_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        result_ready <= calm || ($urandom_range(0, 99) >= 34);

    // Offer one item, with an optional random gap first; return at the edge that takes it.
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
        in_item_t next;
        next.item_value = value;
        next.last_item = last;
        if (!calm && $urandom_range(0, 99) < 34)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 34);
        end
        item_valid <= 1'b1;
        item <= next;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (last)
            sets_sent++;
    endtask

    initial
    begin
        int                 set_len;
        value_style_t       style;
        logic [VALUE_W-1:0] value;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-item sets at both ends of the range, then two- and three-item sets.
        send_item(16'hFFFF, 1'b1);
        send_item(16'h0000, 1'b1);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        repeat (2) send_item(16'hFFFF, 1'b0);
        send_item(16'hFFFF, 1'b1);
        // One item too many, with the last flag on the dropped item.
        for (int k = 0; k < MAX_ITEMS + 1; k++)
            send_item((k < 12) ? 16'hFFFF : 16'h0001, k == MAX_ITEMS);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            calm = (sets_sent >= 90 && sets_sent < 130);
            // Keep sets small; the search time grows fast with the set size.
            if (sets_sent == 60)
                set_len = MAX_ITEMS;
            else if (sets_sent == 150)
                set_len = MAX_ITEMS + $urandom_range(1, 4);
            else
                set_len = $urandom_range(1, 10);
            style = value_style_t'($urandom_range(0, 2));
            for (int k = 0; k < set_len; k++)
            begin
                case (style)
                    FULL_RANGE: value = VALUE_W'($urandom_range(0, 65535));
                    NARROW:     value = VALUE_W'($urandom_range(0, 15));
                    default:    value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                endcase
                send_item(value, k == set_len - 1);
            end
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        @(posedge clk);
        while (gaps_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d items in %0d sets, single-item, full and overflowing sets included;",
                 items_sent, sets_sent);
        $display("compared %0d results under random stalls on both channels.", results_checked);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/btp_pkg.sv
sv/btp_ram.sv
sv/btp_comb_step.sv
sv/balanced_two_team_partition.sv
tb/split_gap_checker.sv
tb/balanced_two_team_partition_test.sv
